// ===== rtl/core/sfs_pkg.sv =====
package sfs_pkg;

    // Table sizes.
    localparam int MAX_FRAMES = 64;
    localparam int MAX_ANIMS  = 16;
    localparam int FRAME_AW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int ANIM_AW    = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 6;
    localparam int FRAME_W = 6;
    localparam int TIME_W  = 24;
    localparam int DT_W    = 16;
    localparam int MODE_W  = 2;
    localparam int RATE_W  = 16;
    localparam int FLAGS_W = 2;
    localparam int FRAC_W  = 8;

    localparam int PROD_W    = DT_W + RATE_W;
    localparam int DIV_NUM_W = TIME_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1 << FRAC_W);

    localparam int FLAG_LOOP = 0;
    localparam int FLAG_REV  = 1;

    // Stream packing, lowest field first.
    localparam int S_SLOT_LO  = 0;
    localparam int S_DUR_LO   = S_SLOT_LO + SLOT_W;
    localparam int S_FROM_LO  = S_DUR_LO + TIME_W;
    localparam int S_TO_LO    = S_FROM_LO + FRAME_W;
    localparam int S_DT_LO    = S_TO_LO + FRAME_W;
    localparam int S_RATE_LO  = S_DT_LO + DT_W;
    localparam int S_FLAGS_LO = S_RATE_LO + RATE_W;
    localparam int S_USED_W   = S_FLAGS_LO + FLAGS_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = CMD_W + MODE_W;

    localparam int M_CUR_LO   = 0;
    localparam int M_TIME_LO  = M_CUR_LO + FRAME_W;
    localparam int M_DONE_LO  = M_TIME_LO + TIME_W;
    localparam int M_PREV_LO  = M_DONE_LO + 1;
    localparam int M_USED_W   = M_PREV_LO + FRAME_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_DEFINE = 2'd1,
        CMD_PLAY   = 2'd2
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        RATE_DEFAULT = 2'd0,
        RATE_GIVEN   = 2'd1,
        RATE_TARGET  = 2'd2
    } rate_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SUM,
        ST_ANIM_WR,
        ST_PLAY_LOOK,
        ST_DIV_WAIT,
        ST_DUR_RD,
        ST_APPLY,
        ST_RESULT
    } seq_state_t;

    typedef struct packed {
        logic [FRAME_W-1:0] first;
        logic [FRAME_W-1:0] last;
        logic [TIME_W-1:0]  total;
    } anim_entry_t;

    localparam int ANIM_ENTRY_W = $bits(anim_entry_t);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/core/sfs_ram.sv =====
module sfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sfs_div.sv =====
module sfs_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [sfs_pkg::DIV_NUM_W-1:0]    dividend,
    input  logic [sfs_pkg::TIME_W-1:0]       divisor,
    output sfs_pkg::div_stat_t               stat,
    output logic [sfs_pkg::DIV_NUM_W-1:0]    quotient
);
    import sfs_pkg::*;

    // Restoring division, one quotient bit per cycle, most significant first.
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0]    dsr_reg, dsr_next;
    logic [TIME_W:0]      shifted;
    logic [TIME_W:0]      diff;
    logic                 ge;

    assign shifted = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = (shifted >= {1'b0, dsr_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== rtl/core/sprite_frame_sequencer_unit.sv =====
// A load or an ignored command goes from decode straight to the result state. A define reads
// one frame duration per cycle and sums them, then writes the descriptor. A play looks up the
// animation, reads a frame duration and applies the step; a zero target skips to the
// result, and a rate derived from a target first waits on the bit-serial divider. One item is
// in flight at a time; a new beat can be taken in the cycle after the result is registered.
// Reset (aresetn low, synchronous) clears only the sequencer state, defined bits, m_tvalid.
module sprite_frame_sequencer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, lowest bit up: slot, duration, anim_from, anim_to, dt, rate_value, mode_flags
    input  logic [sfs_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser, lowest bit up: command, rate_mode
    input  logic [sfs_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, lowest bit up: current_frame, time in frame, done_res, previous_frame
    output logic [sfs_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: status (1 when the command was ignored)
    output logic [sfs_pkg::M_TUSER_W-1:0]   m_tuser
);
    import sfs_pkg::*;

    // The frame durations live in one RAM and the animation descriptors
    // (first, last, summed duration) in another; both have a registered read.
    // Items are handled one at a time, so reads never overlap a pending write.

    seq_state_t state_reg, state_next;

    // Captured input beat.
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [TIME_W-1:0]  dur_in_reg, dur_in_next;
    logic [FRAME_W-1:0] from_reg, from_next;
    logic [FRAME_W-1:0] to_reg, to_next;
    logic [DT_W-1:0]    dt_reg, dt_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [RATE_W-1:0]  rate_in_reg, rate_in_next;
    logic [FLAGS_W-1:0] flags_in_reg, flags_in_next;
    logic [FRAME_W-1:0] prev_reg, prev_next;
    logic               status_reg, status_next;

    // Sequencer state.
    logic [MAX_ANIMS-1:0] defined_reg, defined_next;
    logic [ANIM_AW-1:0]   active_reg, active_next;
    logic                 active_valid_reg, active_valid_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [RATE_W-1:0]    rate_reg, rate_next;
    logic [FLAGS_W-1:0]   flags_reg, flags_next;
    logic                 finished_reg, finished_next;

    // Work registers.
    logic [FRAME_W-1:0] idx_reg, idx_next;
    logic               issued_all_reg, issued_all_next;
    logic               pend_reg, pend_next;
    logic [TIME_W-1:0]  sum_reg, sum_next;
    logic [FRAME_W-1:0] first_reg, first_next;
    logic [FRAME_W-1:0] last_reg, last_next;
    logic               rate_fixed_reg, rate_fixed_next;
    logic               restart_reg, restart_next;
    logic [FRAME_W-1:0] dur_addr_reg, dur_addr_next;
    logic               dur_ok_reg, dur_ok_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;

    // Output register.
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // RAM ports.
    logic                    frame_we;
    logic [FRAME_AW-1:0]     frame_raddr;
    logic [TIME_W-1:0]       frame_rdata;
    logic                    anim_we;
    anim_entry_t             anim_wentry;
    logic [ANIM_ENTRY_W-1:0] anim_rdata;
    anim_entry_t             anim_rentry;

    // Divider.
    logic                 div_start;
    div_stat_t            div_stat;
    logic [DIV_NUM_W-1:0] div_quo;

    // Decoded conditions.
    logic               accept;
    logic               load_ok;
    logic               define_ok;
    logic               play_ok;
    logic               out_free;
    logic               rev;
    logic               loop;
    logic               restart_now;
    logic [TIME_W:0]    sum_add;
    logic [TIME_W-1:0]  dur_val;
    logic [TIME_W-1:0]  inc;
    logic [TIME_W:0]    fwd_add;
    logic [TIME_W-1:0]  fwd_time;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;

    assign load_ok   = (32'(slot_reg) < MAX_FRAMES);
    assign define_ok = (32'(slot_reg) < MAX_ANIMS) && (from_reg <= to_reg)
                       && (32'(to_reg) < MAX_FRAMES);
    assign play_ok   = (32'(slot_reg) < MAX_ANIMS) && defined_reg[slot_reg[ANIM_AW-1:0]];

    assign rev  = flags_in_reg[FLAG_REV];
    assign loop = flags_in_reg[FLAG_LOOP];

    // A different animation, a finished one, or the first play starts over.
    assign restart_now = finished_reg || !active_valid_reg
                         || (slot_reg[ANIM_AW-1:0] != active_reg);

    assign sum_add  = {1'b0, sum_reg} + {1'b0, frame_rdata};
    assign dur_val  = dur_ok_reg ? frame_rdata : '0;
    assign inc      = prod_reg[PROD_W-1:FRAC_W];
    assign fwd_add  = {1'b0, time_reg} + {1'b0, inc};
    assign fwd_time = fwd_add[TIME_W] ? TIME_MAX : fwd_add[TIME_W-1:0];

    assign anim_rentry = anim_entry_t'(anim_rdata);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (cmd_reg)
                    CMD_DEFINE: state_next = define_ok ? ST_SUM : ST_RESULT;
                    CMD_PLAY:   state_next = play_ok ? ST_PLAY_LOOK : ST_RESULT;
                    default:    state_next = ST_RESULT;
                endcase
            end
            ST_SUM: begin
                if (issued_all_reg && pend_reg) begin
                    state_next = ST_ANIM_WR;
                end
            end
            ST_ANIM_WR: state_next = ST_RESULT;
            ST_PLAY_LOOK: begin
                if (mode_reg == RATE_TARGET) begin
                    state_next = (dur_in_reg == '0) ? ST_RESULT : ST_DIV_WAIT;
                end else begin
                    state_next = ST_DUR_RD;
                end
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_DUR_RD;
                end
            end
            ST_DUR_RD: state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        cmd_next          = cmd_reg;
        slot_next         = slot_reg;
        dur_in_next       = dur_in_reg;
        from_next         = from_reg;
        to_next           = to_reg;
        dt_next           = dt_reg;
        mode_next         = mode_reg;
        rate_in_next      = rate_in_reg;
        flags_in_next     = flags_in_reg;
        prev_next         = prev_reg;
        status_next       = status_reg;
        defined_next      = defined_reg;
        active_next       = active_reg;
        active_valid_next = active_valid_reg;
        frame_next        = frame_reg;
        time_next         = time_reg;
        rate_next         = rate_reg;
        flags_next        = flags_reg;
        finished_next     = finished_reg;
        idx_next          = idx_reg;
        issued_all_next   = issued_all_reg;
        pend_next         = pend_reg;
        sum_next          = sum_reg;
        first_next        = first_reg;
        last_next         = last_reg;
        rate_fixed_next   = rate_fixed_reg;
        restart_next      = restart_reg;
        dur_addr_next     = dur_addr_reg;
        dur_ok_next       = dur_ok_reg;
        prod_next         = prod_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        frame_we          = 1'b0;
        frame_raddr       = idx_reg[FRAME_AW-1:0];
        anim_we           = 1'b0;
        anim_wentry       = '{first: from_reg, last: to_reg, total: sum_reg};
        div_start         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next      = s_tuser[CMD_W-1:0];
                    mode_next     = s_tuser[CMD_W +: MODE_W];
                    slot_next     = s_tdata[S_SLOT_LO +: SLOT_W];
                    dur_in_next   = s_tdata[S_DUR_LO +: TIME_W];
                    from_next     = s_tdata[S_FROM_LO +: FRAME_W];
                    to_next       = s_tdata[S_TO_LO +: FRAME_W];
                    dt_next       = s_tdata[S_DT_LO +: DT_W];
                    rate_in_next  = s_tdata[S_RATE_LO +: RATE_W];
                    flags_in_next = s_tdata[S_FLAGS_LO +: FLAGS_W];
                    prev_next     = frame_reg;
                end
            end
            ST_DECODE: begin
                status_next     = 1'b1;
                idx_next        = from_reg;
                issued_all_next = 1'b0;
                pend_next       = 1'b0;
                sum_next        = '0;
                if (cmd_reg == CMD_LOAD && load_ok) begin
                    frame_we    = 1'b1;
                    status_next = 1'b0;
                end
            end
            ST_SUM: begin
                // Reads are issued one frame per cycle; each sum step adds the data of the read issued before it.
                if (pend_reg) begin
                    sum_next = sum_add[TIME_W] ? TIME_MAX : sum_add[TIME_W-1:0];
                end
                if (!issued_all_reg) begin
                    pend_next = 1'b1;
                    if (idx_reg == to_reg) begin
                        issued_all_next = 1'b1;
                    end else begin
                        idx_next = idx_reg + FRAME_W'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_ANIM_WR: begin
                anim_we      = 1'b1;
                defined_next[slot_reg[ANIM_AW-1:0]] = 1'b1;
                status_next  = 1'b0;
            end
            ST_PLAY_LOOK: begin
                first_next      = anim_rentry.first;
                last_next       = anim_rentry.last;
                status_next     = 1'b0;
                rate_fixed_next = 1'b0;
                case (mode_reg)
                    RATE_TARGET: begin
                        if (dur_in_reg == '0) begin
                            // A zero target jumps straight to the end.
                            frame_next    = rev ? anim_rentry.first : anim_rentry.last;
                            finished_next = 1'b1;
                        end else begin
                            div_start       = 1'b1;
                            rate_fixed_next = 1'b1;
                        end
                    end
                    RATE_GIVEN: begin
                        rate_next       = rate_in_reg;
                        rate_fixed_next = 1'b1;
                    end
                    default: ;
                endcase
            end
            ST_DIV_WAIT: begin
                if (div_stat.done) begin
                    rate_next = (div_quo[DIV_NUM_W-1:RATE_W] != '0) ? RATE_MAX
                                                                    : div_quo[RATE_W-1:0];
                end
            end
            ST_DUR_RD: begin
                flags_next   = flags_in_reg;
                restart_next = restart_now;
                // The duration needed next is known before the time compare.
                if (restart_now || (rev && frame_reg <= first_reg)) begin
                    dur_addr_next = last_reg;
                end else if (rev) begin
                    dur_addr_next = frame_reg - FRAME_W'(1);
                end else begin
                    dur_addr_next = frame_reg;
                end
                dur_ok_next = (32'(dur_addr_next) < MAX_FRAMES);
                frame_raddr = dur_addr_next[FRAME_AW-1:0];
                prod_next   = PROD_W'(dt_reg) * PROD_W'(rate_reg);
            end
            ST_APPLY: begin
                if (restart_reg) begin
                    active_next       = slot_reg[ANIM_AW-1:0];
                    active_valid_next = 1'b1;
                    finished_next     = 1'b0;
                    frame_next        = rev ? last_reg : first_reg;
                    time_next         = rev ? dur_val : '0;
                    if (!rate_fixed_reg) begin
                        rate_next = RATE_ONE;
                    end
                end else if (rev) begin
                    if (inc >= time_reg) begin
                        time_next = '0;
                        if (frame_reg <= first_reg) begin
                            if (loop) begin
                                frame_next = last_reg;
                                time_next  = dur_val;
                            end else begin
                                finished_next = 1'b1;
                            end
                        end else begin
                            frame_next = frame_reg - FRAME_W'(1);
                            time_next  = dur_val;
                        end
                    end else begin
                        time_next = time_reg - inc;
                    end
                end else begin
                    if (fwd_time >= dur_val) begin
                        time_next = dur_val;
                        if (frame_reg >= last_reg) begin
                            if (loop) begin
                                frame_next = first_reg;
                                time_next  = '0;
                            end else begin
                                finished_next = 1'b1;
                            end
                        end else begin
                            frame_next = frame_reg + FRAME_W'(1);
                            time_next  = '0;
                        end
                    end else begin
                        time_next = fwd_time;
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[M_CUR_LO +: FRAME_W]  = frame_reg;
                    m_tdata_next[M_TIME_LO +: TIME_W]  = time_reg;
                    m_tdata_next[M_DONE_LO]            = finished_reg;
                    m_tdata_next[M_PREV_LO +: FRAME_W] = prev_reg;
                    m_tuser_next  = M_TUSER_W'(status_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            defined_reg      <= '0;
            active_reg       <= '0;
            active_valid_reg <= 1'b0;
            frame_reg        <= '0;
            time_reg         <= '0;
            rate_reg         <= RATE_ONE;
            flags_reg        <= '0;
            finished_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            defined_reg      <= defined_next;
            active_reg       <= active_next;
            active_valid_reg <= active_valid_next;
            frame_reg        <= frame_next;
            time_reg         <= time_next;
            rate_reg         <= rate_next;
            flags_reg        <= flags_next;
            finished_reg     <= finished_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
        cmd_reg        <= cmd_next;
        slot_reg       <= slot_next;
        dur_in_reg     <= dur_in_next;
        from_reg       <= from_next;
        to_reg         <= to_next;
        dt_reg         <= dt_next;
        mode_reg       <= mode_next;
        rate_in_reg    <= rate_in_next;
        flags_in_reg   <= flags_in_next;
        prev_reg       <= prev_next;
        status_reg     <= status_next;
        idx_reg        <= idx_next;
        issued_all_reg <= issued_all_next;
        pend_reg       <= pend_next;
        sum_reg        <= sum_next;
        first_reg      <= first_next;
        last_reg       <= last_next;
        rate_fixed_reg <= rate_fixed_next;
        restart_reg    <= restart_next;
        dur_addr_reg   <= dur_addr_next;
        dur_ok_reg     <= dur_ok_next;
        prod_reg       <= prod_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    sfs_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_FRAMES)
    ) u_frame_ram (
        .aclk  (aclk),
        .we    (frame_we),
        .waddr (slot_reg[FRAME_AW-1:0]),
        .wdata (dur_in_reg),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    sfs_ram #(
        .WIDTH (ANIM_ENTRY_W),
        .DEPTH (MAX_ANIMS)
    ) u_anim_ram (
        .aclk  (aclk),
        .we    (anim_we),
        .waddr (slot_reg[ANIM_AW-1:0]),
        .wdata (anim_wentry),
        .raddr (slot_reg[ANIM_AW-1:0]),
        .rdata (anim_rdata)
    );

    // Derived rate: summed duration scaled by one unit of rate, over the target.
    sfs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({anim_rentry.total, FRAC_W'(0)}),
        .divisor  (dur_in_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // The divider only runs while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> state_reg == ST_DIV_WAIT)
        else $error("divider busy outside its wait state");

    // The active animation always points at a defined slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        active_valid_reg |-> defined_reg[active_reg])
        else $error("active animation is not defined");

    // A new result beat is only produced from the result state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_RESULT)
        else $error("result beat raised outside the result state");

    // An accepted beat always goes to decode next.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_DECODE)
        else $error("accepted beat not decoded");

endmodule

// ===== bench/sfs_tb_pkg.sv =====
`timescale 1ns / 1ps

package sfs_tb_pkg;

    import sfs_pkg::*;

    // Codes the block has no name for but must ignore or treat as the default.
    localparam logic [CMD_W-1:0]   CMD_BAD  = 2'd3;
    localparam logic [MODE_W-1:0]  RATE_BAD = 2'd3;

    // Play flag combinations.
    localparam logic [FLAGS_W-1:0] PLAY_FWD      = 2'b00;
    localparam logic [FLAGS_W-1:0] PLAY_LOOP     = 2'b01;
    localparam logic [FLAGS_W-1:0] PLAY_REV      = 2'b10;
    localparam logic [FLAGS_W-1:0] PLAY_REV_LOOP = 2'b11;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SLOT_W-1:0]  slot;
        logic [TIME_W-1:0]  duration;
        logic [FRAME_W-1:0] from;
        logic [FRAME_W-1:0] to;
        logic [DT_W-1:0]    dt;
        logic [MODE_W-1:0]  mode;
        logic [RATE_W-1:0]  rate;
        logic [FLAGS_W-1:0] flags;
    } seq_item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [TIME_W-1:0]  ftime;
        logic               done;
        logic [FRAME_W-1:0] prev;
        logic               status;
    } seq_result_t;

    class sequencer_board;

        // Shadow of the sequencer tables and play state.
        logic [TIME_W-1:0]  frame_dur [MAX_FRAMES];
        bit                 frame_loaded [MAX_FRAMES];
        logic [FRAME_W-1:0] anim_lo [MAX_ANIMS];
        logic [FRAME_W-1:0] anim_hi [MAX_ANIMS];
        logic [TIME_W-1:0]  anim_total [MAX_ANIMS];
        bit                 anim_def [MAX_ANIMS];
        logic [ANIM_AW-1:0] active_anim;
        bit                 active_ok;
        logic [FRAME_W-1:0] frame_now;
        logic [TIME_W-1:0]  time_in;
        logic [RATE_W-1:0]  play_rate;
        logic [FLAGS_W-1:0] play_flags;
        bit                 finished;

        seq_result_t expected_frames [$];
        int n_loads, n_defines, n_plays, n_ignored, n_checked, n_errors;

        function new();
            foreach (frame_loaded[i]) frame_loaded[i] = 1'b0;
            foreach (anim_def[i]) anim_def[i] = 1'b0;
            active_anim = '0;
            active_ok   = 1'b0;
            frame_now   = '0;
            time_in     = '0;
            play_rate   = RATE_ONE;
            play_flags  = '0;
            finished    = 1'b0;
        endfunction

        // Reads a frame duration and remembers whether it was ever loaded.
        function logic [TIME_W-1:0] frame_len(logic [FRAME_W-1:0] f, inout bit hit);
            if (!frame_loaded[f]) hit = 1'b1;
            return frame_dur[f];
        endfunction

        // Works out the result of one command. State is only updated when commit is set,
        // so the stimulus side can also ask whether a command would touch an unloaded frame.
        function void predict(input seq_item_t it, input bit commit,
                              output seq_result_t r, output bit hit);
            logic [FRAME_W-1:0] fr, lo_fr, hi_fr;
            logic [TIME_W-1:0]  tm, inc, d;
            logic [RATE_W-1:0]  rt;
            logic [FLAGS_W-1:0] fl;
            logic [ANIM_AW-1:0] act, aslot;
            logic [TIME_W:0]    sum, t;
            logic [31:0]        q, prod;
            bit                 act_ok, fin, rate_fixed, status;

            hit    = 1'b0;
            fr     = frame_now;
            tm     = time_in;
            rt     = play_rate;
            fl     = play_flags;
            act    = active_anim;
            act_ok = active_ok;
            fin    = finished;
            status = 1'b1;

            case (it.cmd)
                CMD_LOAD: begin
                    if (it.slot < MAX_FRAMES) begin
                        status = 1'b0;
                        if (commit) begin
                            frame_dur[it.slot]    = it.duration;
                            frame_loaded[it.slot] = 1'b1;
                        end
                    end
                end
                CMD_DEFINE: begin
                    if (it.slot < MAX_ANIMS && it.from <= it.to && it.to < MAX_FRAMES) begin
                        sum = '0;
                        for (int i = it.from; i <= it.to; i++) begin
                            sum = sum + {1'b0, frame_len(FRAME_W'(i), hit)};
                            if (sum > {1'b0, TIME_MAX}) sum = {1'b0, TIME_MAX};
                        end
                        status = 1'b0;
                        if (commit) begin
                            aslot             = it.slot[ANIM_AW-1:0];
                            anim_lo[aslot]    = it.from;
                            anim_hi[aslot]    = it.to;
                            anim_total[aslot] = sum[TIME_W-1:0];
                            anim_def[aslot]   = 1'b1;
                        end
                    end
                end
                CMD_PLAY: begin
                    if (it.slot < MAX_ANIMS && anim_def[it.slot[ANIM_AW-1:0]]) begin
                        status     = 1'b0;
                        aslot      = it.slot[ANIM_AW-1:0];
                        lo_fr      = anim_lo[aslot];
                        hi_fr      = anim_hi[aslot];
                        rate_fixed = 1'b0;
                        if (it.mode == RATE_TARGET && it.duration == '0) begin
                            // A zero target jumps straight to the end and leaves all else alone.
                            fr  = it.flags[FLAG_REV] ? lo_fr : hi_fr;
                            fin = 1'b1;
                        end else begin
                            if (it.mode == RATE_TARGET) begin
                                q          = {anim_total[aslot], 8'h00} / 32'(it.duration);
                                rt         = (q > 32'(RATE_MAX)) ? RATE_MAX : q[RATE_W-1:0];
                                rate_fixed = 1'b1;
                            end else if (it.mode == RATE_GIVEN) begin
                                rt         = it.rate;
                                rate_fixed = 1'b1;
                            end
                            fl = it.flags;
                            if (fin || !act_ok || aslot != act) begin
                                act    = aslot;
                                act_ok = 1'b1;
                                fin    = 1'b0;
                                if (fl[FLAG_REV]) begin
                                    fr = hi_fr;
                                    tm = frame_len(hi_fr, hit);
                                end else begin
                                    fr = lo_fr;
                                    tm = '0;
                                end
                                if (!rate_fixed) rt = RATE_ONE;
                            end else begin
                                prod = 32'(it.dt) * 32'(rt);
                                inc  = prod[31:FRAC_W];
                                if (fl[FLAG_REV]) begin
                                    if (inc >= tm) begin
                                        tm = '0;
                                        if (fr <= lo_fr) begin
                                            if (fl[FLAG_LOOP]) begin
                                                fr = hi_fr;
                                                tm = frame_len(fr, hit);
                                            end else begin
                                                fin = 1'b1;
                                            end
                                        end else begin
                                            fr = fr - FRAME_W'(1);
                                            tm = frame_len(fr, hit);
                                        end
                                    end else begin
                                        tm = tm - inc;
                                    end
                                end else begin
                                    d = frame_len(fr, hit);
                                    t = {1'b0, tm} + {1'b0, inc};
                                    if (t > {1'b0, TIME_MAX}) t = {1'b0, TIME_MAX};
                                    tm = t[TIME_W-1:0];
                                    if (tm >= d) begin
                                        tm = d;
                                        if (fr >= hi_fr) begin
                                            if (fl[FLAG_LOOP]) begin
                                                fr = lo_fr;
                                                tm = '0;
                                            end else begin
                                                fin = 1'b1;
                                            end
                                        end else begin
                                            fr = fr + FRAME_W'(1);
                                            tm = '0;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase

            r.frame  = fr;
            r.ftime  = tm;
            r.done   = fin;
            r.prev   = frame_now;
            r.status = status;

            if (commit) begin
                frame_now   = fr;
                time_in     = tm;
                play_rate   = rt;
                play_flags  = fl;
                active_anim = act;
                active_ok   = act_ok;
                finished    = fin;
            end
        endfunction

        function void note_command(seq_item_t it);
            seq_result_t r;
            bit          hit;
            predict(it, 1'b1, r, hit);
            expected_frames.push_back(r);
            if (r.status) n_ignored++;
            else if (it.cmd == CMD_LOAD) n_loads++;
            else if (it.cmd == CMD_DEFINE) n_defines++;
            else n_plays++;
        endfunction

        task flag_mismatch(string msg);
            n_errors++;
            $display("ERROR: %s", msg);
        endtask

        task check_frame(seq_result_t got);
            seq_result_t want;
            if (expected_frames.size() == 0) begin
                flag_mismatch($sformatf("result beat with nothing outstanding (frame %0d)",
                                        got.frame));
                return;
            end
            want = expected_frames.pop_front();
            n_checked++;
            if (got.frame !== want.frame)
                flag_mismatch($sformatf("result %0d current_frame %0d, want %0d",
                                        n_checked, got.frame, want.frame));
            if (got.ftime !== want.ftime)
                flag_mismatch($sformatf("result %0d time in frame %h, want %h",
                                        n_checked, got.ftime, want.ftime));
            if (got.done !== want.done)
                flag_mismatch($sformatf("result %0d done_res %b, want %b",
                                        n_checked, got.done, want.done));
            if (got.prev !== want.prev)
                flag_mismatch($sformatf("result %0d previous_frame %0d, want %0d",
                                        n_checked, got.prev, want.prev));
            if (got.status !== want.status)
                flag_mismatch($sformatf("result %0d status %b, want %b",
                                        n_checked, got.status, want.status));
        endtask

        task drain_check();
            if (expected_frames.size() != 0)
                flag_mismatch($sformatf("%0d results never arrived", expected_frames.size()));
        endtask

    endclass

endpackage

// ===== bench/sprite_frame_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps

module sprite_frame_sequencer_unit_tb;

    import sfs_pkg::*;
    import sfs_tb_pkg::*;

    // Number of random commands sent after the directed opening.
    localparam int RANDOM_BEATS = 1625;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // While set, neither side inserts idle cycles.
    bit steady = 1'b0;

    sequencer_board board;

    sprite_frame_sequencer_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The run is bounded by a fixed time well beyond the slowest correct run: even if every
    // command were a 64-frame define with long stalls on both sides it ends far sooner.
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic seq_item_t compose(
        logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] duration,
        logic [FRAME_W-1:0] from, logic [FRAME_W-1:0] to, logic [DT_W-1:0] dt,
        logic [MODE_W-1:0] mode, logic [RATE_W-1:0] rate, logic [FLAGS_W-1:0] flags);
        seq_item_t it;
        it.cmd      = cmd;
        it.slot     = slot;
        it.duration = duration;
        it.from     = from;
        it.to       = to;
        it.dt       = dt;
        it.mode     = mode;
        it.rate     = rate;
        it.flags    = flags;
        return it;
    endfunction

    // Times are mostly short so that plays cross frame edges often; the rest spans the field.
    function automatic logic [TIME_W-1:0] pick_time();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return TIME_W'($urandom_range(0, 'h400));
        if (p < 85) return TIME_W'($urandom_range(0, 'hFFFF));
        if (p < 95) return TIME_W'($urandom);
        return (p < 97) ? '0 : TIME_MAX;
    endfunction

    // Draws one random command. Unused fields keep random bits, so every input bit toggles.
    // Most commands are loads, defines over short ranges and runs of plays on the active
    // animation; a few are out-of-range slots, reversed ranges and unknown commands.
    function automatic seq_item_t draw_item();
        seq_item_t   it;
        logic [95:0] raw;
        int          pick, lo, span, f;
        raw  = {$urandom, $urandom, $urandom};
        it   = raw[$bits(seq_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            it.cmd = CMD_LOAD;
            if ($urandom_range(0, 1) == 1) begin
                // Half the loads fill the table, starting from a random spot.
                f = $urandom_range(0, MAX_FRAMES - 1);
                for (int k = 0; k < MAX_FRAMES; k++) begin
                    if (!board.frame_loaded[(f + k) % MAX_FRAMES]) begin
                        it.slot = SLOT_W'((f + k) % MAX_FRAMES);
                        break;
                    end
                end
            end
            it.duration = pick_time();
        end else if (pick < 30) begin
            it.cmd = CMD_DEFINE;
            if ($urandom_range(0, 9) == 0) it.slot = SLOT_W'($urandom_range(MAX_ANIMS, 63));
            else it.slot = SLOT_W'($urandom_range(0, MAX_ANIMS - 1));
            lo   = $urandom_range(0, MAX_FRAMES - 1);
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_FRAMES - 1)
                                               : $urandom_range(0, 5);
            it.from = FRAME_W'(lo);
            it.to   = (lo + span > MAX_FRAMES - 1) ? FRAME_W'(MAX_FRAMES - 1)
                                                   : FRAME_W'(lo + span);
            if ($urandom_range(0, 9) == 0 && it.from != it.to) begin
                f       = int'(it.from);
                it.from = it.to;
                it.to   = FRAME_W'(f);
            end
        end else if (pick < 94) begin
            it.cmd = CMD_PLAY;
            if (board.active_ok && $urandom_range(0, 99) < 70)
                it.slot = SLOT_W'(board.active_anim);
            else if ($urandom_range(0, 19) == 0) it.slot = SLOT_W'($urandom_range(0, 63));
            else it.slot = SLOT_W'($urandom_range(0, MAX_ANIMS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 55) it.mode = RATE_DEFAULT;
            else if (pick < 75) it.mode = RATE_GIVEN;
            else if (pick < 95) it.mode = RATE_TARGET;
            else it.mode = RATE_BAD;
            if (it.mode == RATE_TARGET)
                it.duration = ($urandom_range(0, 9) == 0) ? '0 : pick_time();
            if ($urandom_range(0, 99) < 70) it.dt = DT_W'($urandom_range(0, 'h300));
            if ($urandom_range(0, 99) < 60) it.rate = RATE_W'($urandom_range(0, 'h400));
        end else begin
            it.cmd = CMD_BAD;
        end
        return it;
    endfunction

    // Presents one command beat and holds it until the block takes it.
    task automatic push_beat(input seq_item_t it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[S_SLOT_LO  +: SLOT_W]  = it.slot;
        d[S_DUR_LO   +: TIME_W]  = it.duration;
        d[S_FROM_LO  +: FRAME_W] = it.from;
        d[S_TO_LO    +: FRAME_W] = it.to;
        d[S_DT_LO    +: DT_W]    = it.dt;
        d[S_RATE_LO  +: RATE_W]  = it.rate;
        d[S_FLAGS_LO +: FLAGS_W] = it.flags;
        s_tdata  <= d;
        s_tuser  <= {it.mode, it.cmd};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_command(it);
    endtask

    // Random idle cycles on the command side. Valid only drops when a gap is taken, so it is
    // never lowered and raised in the same step.
    task automatic idle_source();
        int gap;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(0, 99) < 26) gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Result side: sample the handshake with the values that stood at the edge, then pick the
    // ready level for the next cycle.
    initial begin
        seq_result_t got;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.frame  = m_tdata[M_CUR_LO  +: FRAME_W];
                got.ftime  = m_tdata[M_TIME_LO +: TIME_W];
                got.done   = m_tdata[M_DONE_LO];
                got.prev   = m_tdata[M_PREV_LO +: FRAME_W];
                got.status = m_tuser[0];
                board.check_frame(got);
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 26);
        end
    end

    initial begin
        seq_item_t   opening [$];
        seq_item_t   it;
        seq_result_t guess;
        bit          hit;
        int          idx;

        board    = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening. Frames 0..2 are short (one of them zero length), frames 62 and 63
        // hold the largest duration so that sums, derived rates and forward time saturate.
        // Play of an undefined animation and an unknown command are both ignored.
        opening.push_back(compose(CMD_PLAY, 0, 0, 0, 0, 'h100, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_BAD, 63, TIME_MAX, 63, 63, 'hFFFF, RATE_BAD, 'hFFFF,
                                  PLAY_REV_LOOP));
        opening.push_back(compose(CMD_LOAD, 0, 'h100, 0, 0, 0, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_LOAD, 1, 'h200, 0, 0, 0, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_LOAD, 2, 0, 0, 0, 0, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_LOAD, 63, TIME_MAX, 0, 0, 0, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_LOAD, 62, TIME_MAX, 0, 0, 0, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_DEFINE, 0, 0, 0, 2, 0, RATE_DEFAULT, 0, PLAY_FWD));
        // The total of this one saturates.
        opening.push_back(compose(CMD_DEFINE, 15, 0, 62, 63, 0, RATE_DEFAULT, 0, PLAY_FWD));
        // Slot beyond the animation table, then a range with from after to: both ignored.
        opening.push_back(compose(CMD_DEFINE, 16, 0, 0, 1, 0, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_DEFINE, 1, 0, 2, 1, 0, RATE_DEFAULT, 0, PLAY_FWD));
        // Start, step one frame, then a huge given rate runs onto the zero-length frame and
        // an unknown rate mode keeps that rate and loops back.
        opening.push_back(compose(CMD_PLAY, 0, 0, 0, 0, 'h100, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_PLAY, 0, 0, 0, 0, 'h180, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_PLAY, 0, 0, 0, 0, 'hFFFF, RATE_GIVEN, 'hFFFF, PLAY_LOOP));
        opening.push_back(compose(CMD_PLAY, 0, 0, 0, 0, 'h100, RATE_BAD, 0, PLAY_LOOP));
        // Reverse start with a derived rate that saturates, then walk back across a frame.
        opening.push_back(compose(CMD_PLAY, 15, 1, 0, 0, 0, RATE_TARGET, 0, PLAY_REV));
        opening.push_back(compose(CMD_PLAY, 15, 0, 0, 0, 'hFFFF, RATE_GIVEN, 'hFFFF, PLAY_REV));
        opening.push_back(compose(CMD_PLAY, 15, 0, 0, 0, 'hFFFF, RATE_GIVEN, 'hFFFF, PLAY_REV));
        // Forward from a full frame: time saturates and the frame advances.
        opening.push_back(compose(CMD_PLAY, 15, 0, 0, 0, 'hFFFF, RATE_GIVEN, 'hFFFF, PLAY_FWD));
        // Zero target jumps to the first frame in reverse and to the last one forward.
        opening.push_back(compose(CMD_PLAY, 15, 0, 0, 0, 'h10, RATE_TARGET, 0, PLAY_REV));
        opening.push_back(compose(CMD_PLAY, 15, 0, 0, 0, 'h10, RATE_TARGET, 0, PLAY_FWD));
        // A finished animation restarts; then the active slot is redefined under it.
        opening.push_back(compose(CMD_PLAY, 15, 0, 0, 0, 'h10, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_DEFINE, 15, 0, 62, 62, 0, RATE_DEFAULT, 0, PLAY_FWD));
        opening.push_back(compose(CMD_PLAY, 15, 0, 0, 0, 'hFFFF, RATE_GIVEN, 'hFFFF, PLAY_FWD));
        opening.push_back(compose(CMD_PLAY, 15, 0, 0, 0, 'hFFFF, RATE_GIVEN, 'hFFFF, PLAY_FWD));

        foreach (opening[i]) begin
            push_beat(opening[i]);
            idle_source();
        end

        // Random part. A drawn command that would read a frame duration never loaded is
        // thrown away and drawn again; a load is always safe, so this always ends.
        idx = 0;
        while (idx < RANDOM_BEATS) begin
            steady = (idx >= 500 && idx < 800);
            do begin
                it = draw_item();
                board.predict(it, 1'b0, guess, hit);
            end while (hit);
            push_beat(it);
            idx++;
            idle_source();
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // Wait for the last results, then long enough for the slowest define to show any
        // stray beat.
        while (board.expected_frames.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        board.drain_check();

        $display("Commands: %0d loads, %0d defines, %0d plays, %0d ignored",
                 board.n_loads, board.n_defines, board.n_plays, board.n_ignored);
        $display("Results compared: %0d, mismatches: %0d", board.n_checked, board.n_errors);
        if (board.n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/sfs_pkg.sv
rtl/core/sfs_ram.sv
rtl/core/sfs_div.sv
rtl/core/sprite_frame_sequencer_unit.sv
bench/sfs_tb_pkg.sv
bench/sprite_frame_sequencer_unit_tb.sv
